// File: hw/rtl/rcsfp_pkg.sv
// Shared constants and types for the servo frame parser.
package rcsfp_pkg;

    localparam int CHANNELS    = 10;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W      = CH_W + 1;
    localparam int MEM_DEPTH   = 2 ** ADDR_W;
    localparam int IDX_W       = 4;
    localparam int VAL_W       = 16;
    localparam int MS_W        = 32;
    localparam int POS_W       = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;

    localparam logic [7:0]       SYNC_BYTE = 8'h20;
    localparam logic [7:0]       CMD_BYTE  = 8'h40;
    localparam logic [15:0]      SUM_START = 16'hFFFF;
    localparam logic [POS_W-1:0] SUM_BYTES = 5'd30;
    localparam logic [POS_W-1:0] LAST_POS  = 5'd31;
    localparam logic [POS_W-1:0] FIRST_CH_POS = 5'd2;
    localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(CHANNELS - 1);

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [VAL_W-1:0]  data;
    } mem_wr_t;

    typedef struct packed {
        logic done;
        logic ok;
    } frame_evt_t;

endpackage

// File: hw/rtl/rc_servo_frame_parser_top.sv
// Top level of the 32-byte servo frame parser.
//
// The input stream carries one received byte and its millisecond time stamp
// per word. Bytes before a 0x20 sync byte are dropped; from there 32 bytes
// form one frame whose header and checksum are checked on the last byte.
// Channel values are written into an inactive bank of a small two-bank
// memory as they arrive, and a good frame swaps the banks, so the latched
// values never need copying. An input word is taken each cycle one is offered,
// except as noted below. After the last byte of any frame the output stream
// carries one word per channel, ten in all: the first passes the run flag,
// read stage and output register, the rest follow one per cycle while the
// receiver is ready. The last word of a burst has tlast set. A stalled
// receiver holds the burst; the input keeps taking bytes and only waits at
// the last byte of the next frame until the previous burst has fully drained.
// Reset clears the frame position, checksum, flags, time stamp and output
// pipeline; the block is ready as soon as reset is released.
module rc_servo_frame_parser_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: rx_byte[7:0], now_ms[39:8].
    input  logic [rcsfp_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: channel_index[3:0], channel_value[19:4], last_frame_ms[51:20], zeros.
    output logic [rcsfp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: frame_ok[0], ever_good[1].
    output logic [rcsfp_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                              m_tlast
);
    import rcsfp_pkg::*;

    mem_wr_t             mem_wr;
    frame_evt_t          evt;
    logic                bank;
    logic                ever_good;
    logic [MS_W-1:0]     last_ms;
    logic [ADDR_W-1:0]   rd_addr;
    logic [VAL_W-1:0]    rd_data;
    logic                emit_busy;

    rcsfp_rx u_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .emit_busy (emit_busy),
        .mem_wr    (mem_wr),
        .evt       (evt),
        .bank      (bank),
        .ever_good (ever_good),
        .last_ms   (last_ms)
    );

    rcsfp_chmem u_chmem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcsfp_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (evt),
        .bank      (bank),
        .ever_good (ever_good),
        .last_ms   (last_ms),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .busy      (emit_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: hw/rtl/rcsfp_chmem.sv
// Channel value memory: two banks, one write port, one registered read port.
module rcsfp_chmem (
    input  logic                        aclk,
    input  rcsfp_pkg::mem_wr_t          wr,
    input  logic [rcsfp_pkg::ADDR_W-1:0] rd_addr,
    output logic [rcsfp_pkg::VAL_W-1:0]  rd_data
);
    import rcsfp_pkg::*;

    logic [VAL_W-1:0] mem [0:MEM_DEPTH-1];
    logic [VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rcsfp_rx.sv
// Byte parser: frame position, header and checksum tracking, channel writes.
module rcsfp_rx (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rcsfp_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                             emit_busy,
    output rcsfp_pkg::mem_wr_t               mem_wr,
    output rcsfp_pkg::frame_evt_t            evt,
    output logic                             bank,
    output logic                             ever_good,
    output logic [rcsfp_pkg::MS_W-1:0]       last_ms
);
    import rcsfp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic             hdr_reg, hdr_next;
    logic [7:0]       cks_lo_reg, cks_lo_next;
    logic [7:0]       lo_byte_reg, lo_byte_next;
    logic             bank_reg, bank_next;
    logic             ever_reg, ever_next;
    logic [MS_W-1:0]  last_ms_reg, last_ms_next;

    logic             accept;
    logic [7:0]       rx_byte;
    logic [MS_W-1:0]  now_ms;
    logic [POS_W-1:0] rel;
    logic [3:0]       ch;
    logic             is_ch;
    logic             ok;

    assign rx_byte  = s_tdata[7:0];
    assign now_ms   = s_tdata[39:8];
    assign s_tready = !(emit_busy && (pos_reg == LAST_POS));
    assign accept   = s_tvalid && s_tready;

    assign rel   = pos_reg - FIRST_CH_POS;
    assign ch    = rel[4:1];
    assign is_ch = (pos_reg >= FIRST_CH_POS) && (pos_reg < SUM_BYTES)
                   && ({1'b0, ch} < POS_W'(CHANNELS));
    assign ok    = hdr_reg && (sum_reg == {rx_byte, cks_lo_reg});

    assign mem_wr.en   = accept && is_ch && rel[0];
    assign mem_wr.addr = {~bank_reg, ch[CH_W-1:0]};
    assign mem_wr.data = {rx_byte, lo_byte_reg};

    assign evt.done  = accept && (pos_reg == LAST_POS);
    assign evt.ok    = ok;
    assign bank      = bank_reg;
    assign ever_good = ever_reg;
    assign last_ms   = last_ms_reg;

    always_comb begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        hdr_next     = hdr_reg;
        cks_lo_next  = cks_lo_reg;
        lo_byte_next = lo_byte_reg;
        bank_next    = bank_reg;
        ever_next    = ever_reg;
        last_ms_next = last_ms_reg;
        if (accept && !((pos_reg == '0) && (rx_byte != SYNC_BYTE))) begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == '0) begin
                hdr_next = 1'b1;
            end else if (pos_reg == POS_W'(1)) begin
                hdr_next = hdr_reg && (rx_byte == CMD_BYTE);
            end
            if (pos_reg < SUM_BYTES) begin
                sum_next = sum_reg - {8'h00, rx_byte};
            end
            if (is_ch && !rel[0]) begin
                lo_byte_next = rx_byte;
            end
            if (pos_reg == SUM_BYTES) begin
                cks_lo_next = rx_byte;
            end
            if (pos_reg == LAST_POS) begin
                pos_next = '0;
                sum_next = SUM_START;
                hdr_next = 1'b0;
                if (ok) begin
                    bank_next    = ~bank_reg;
                    ever_next    = 1'b1;
                    last_ms_next = now_ms;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sum_reg     <= SUM_START;
            hdr_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            ever_reg    <= 1'b0;
            last_ms_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            hdr_reg     <= hdr_next;
            bank_reg    <= bank_next;
            ever_reg    <= ever_next;
            last_ms_reg <= last_ms_next;
        end
        cks_lo_reg  <= cks_lo_next;
        lo_byte_reg <= lo_byte_next;
    end

endmodule

// File: hw/rtl/rcsfp_emit.sv
// Result sequencer: reads the latched bank and streams one word per channel.
module rcsfp_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rcsfp_pkg::frame_evt_t             evt,
    input  logic                              bank,
    input  logic                              ever_good,
    input  logic [rcsfp_pkg::MS_W-1:0]        last_ms,
    output logic [rcsfp_pkg::ADDR_W-1:0]      rd_addr,
    input  logic [rcsfp_pkg::VAL_W-1:0]       rd_data,
    output logic                              busy,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rcsfp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [rcsfp_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                              m_tlast
);
    import rcsfp_pkg::*;

    logic             run_reg, run_next;
    logic [CH_W-1:0]  k_reg, k_next;
    logic             ok_reg, ok_next;
    logic             r1_valid_reg, r1_valid_next;
    logic [CH_W-1:0]  r1_idx_reg, r1_idx_next;
    logic             r1_last_reg, r1_last_next;
    logic             m_valid_reg, m_valid_next;
    logic [CH_W-1:0]  m_idx_reg, m_idx_next;
    logic             m_last_reg, m_last_next;
    logic [VAL_W-1:0] m_value_reg, m_value_next;
    logic             adv;

    assign adv     = !m_valid_reg || m_tready;
    assign rd_addr = {bank, adv ? k_reg : r1_idx_reg};
    assign busy    = run_reg || r1_valid_reg || m_valid_reg;

    always_comb begin
        run_next      = run_reg;
        k_next        = k_reg;
        ok_next       = ok_reg;
        r1_valid_next = r1_valid_reg;
        r1_idx_next   = r1_idx_reg;
        r1_last_next  = r1_last_reg;
        m_valid_next  = m_valid_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;
        m_value_next  = m_value_reg;
        if (adv) begin
            m_valid_next  = r1_valid_reg;
            m_idx_next    = r1_idx_reg;
            m_last_next   = r1_last_reg;
            m_value_next  = ever_good ? rd_data : '0;
            r1_valid_next = run_reg;
            r1_idx_next   = k_reg;
            r1_last_next  = (k_reg == LAST_CH);
            if (run_reg) begin
                if (k_reg == LAST_CH) begin
                    run_next = 1'b0;
                end else begin
                    k_next = k_reg + CH_W'(1);
                end
            end
        end
        if (evt.done) begin
            run_next = 1'b1;
            k_next   = '0;
            ok_next  = evt.ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg      <= 1'b0;
            k_reg        <= '0;
            ok_reg       <= 1'b0;
            r1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            run_reg      <= run_next;
            k_reg        <= k_next;
            ok_reg       <= ok_next;
            r1_valid_reg <= r1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
        r1_idx_reg  <= r1_idx_next;
        r1_last_reg <= r1_last_next;
        m_idx_reg   <= m_idx_next;
        m_last_reg  <= m_last_next;
        m_value_reg <= m_value_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, last_ms, m_value_reg, IDX_W'(m_idx_reg)};
    assign m_tuser  = {ever_good, ok_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the 32-byte servo frame parser.
`timescale 1ns / 100ps

module tb;
    import rcsfp_pkg::*;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP,
        FILL_RAND
    } fill_e;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             ok;
        logic             ever;
        logic [MS_W-1:0]  ms;
        logic             last;
    } chan_rpt_t;

    typedef struct packed {
        int                lead;
        logic [7:0]        hdr;
        logic [15:0]       sum_err;
        fill_e             fill;
        logic [MS_W-1:0]   stamp;
        logic              typed;
        logic              t_ok;
        logic              t_ever;
        logic [VAL_W-1:0]  t_val;
        logic [MS_W-1:0]   t_ms;
    } frame_row_t;

    localparam int NUM_ROWS = 7;

    // Rows with typed set carry the expected report; the rest are predicted.
    localparam frame_row_t FRAME_PLAN [NUM_ROWS] = '{
        '{6, 8'h00,     16'h0000, FILL_ONES, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0},
        '{0, CMD_BYTE,  16'h0001, FILL_RAMP, 32'h1234_5678, 1'b1, 1'b0, 1'b0, 16'h0000, 32'h0},
        '{1, CMD_BYTE,  16'h0000, FILL_ZERO, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 16'h0000, 32'h0},
        '{0, CMD_BYTE,  16'h0000, FILL_ONES, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 16'hFFFF,
          32'hFFFF_FFFF},
        '{2, 8'h41,     16'h0000, FILL_RAND, 32'h0000_0001, 1'b1, 1'b0, 1'b1, 16'hFFFF,
          32'hFFFF_FFFF},
        '{0, SYNC_BYTE, 16'h8000, FILL_RAMP, 32'h0000_0005, 1'b1, 1'b0, 1'b1, 16'hFFFF,
          32'hFFFF_FFFF},
        '{3, CMD_BYTE,  16'h0000, FILL_RAMP, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 16'h0000, 32'h0}
    };

    localparam logic [7:0] IDLE_PATTERN [6] = '{8'h00, 8'hFF, 8'h40, 8'h1F, 8'h21, 8'hA0};

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    logic [POS_W-1:0] rx_pos = '0;
    logic [15:0]      rx_sum = SUM_START;
    logic             rx_hdr_ok = 1'b0;
    logic [7:0]       rx_ck_lo = '0;
    logic [VAL_W-1:0] rx_pend [CHANNELS];
    logic [VAL_W-1:0] held_ch [CHANNELS];
    logic             held_ever = 1'b0;
    logic [MS_W-1:0]  held_ms = '0;

    chan_rpt_t burst_q [$];
    chan_rpt_t head_rpt;
    bit        failed = 1'b0;
    bit        tx_calm = 1'b0;
    int        words_sent = 0;
    int        frames_seen = 0;
    int        idle_seq = 0;
    int        rx_hold = 0;
    int        rx_calm_left = 0;
    bit        rx_calm = 1'b0;

    rc_servo_frame_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic int idle_len();
        if ($urandom_range(0, 19) < 16) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == SYNC_BYTE);
        return b;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic [MS_W-1:0] now);
        logic      ok;
        int        c;
        chan_rpt_t r;
        if (rx_pos == 0 && b != SYNC_BYTE) begin
            return;
        end
        if (rx_pos == 0) begin
            rx_hdr_ok = 1'b1;
        end else if (rx_pos == 1) begin
            rx_hdr_ok = rx_hdr_ok && (b == CMD_BYTE);
        end
        if (rx_pos < SUM_BYTES) begin
            rx_sum = rx_sum - 16'(b);
        end
        if (rx_pos >= FIRST_CH_POS && rx_pos < SUM_BYTES) begin
            c = (int'(rx_pos) - 2) >> 1;
            if (c < CHANNELS) begin
                if (!rx_pos[0]) begin
                    rx_pend[c][7:0] = b;
                end else begin
                    rx_pend[c][15:8] = b;
                end
            end
        end
        if (rx_pos == SUM_BYTES) begin
            rx_ck_lo = b;
        end
        if (rx_pos != LAST_POS) begin
            rx_pos = rx_pos + 1'b1;
            return;
        end
        ok = rx_hdr_ok && (rx_sum == {b, rx_ck_lo});
        if (ok) begin
            held_ch = rx_pend;
            held_ms = now;
            held_ever = 1'b1;
        end
        rx_pos = '0;
        rx_sum = SUM_START;
        rx_hdr_ok = 1'b0;
        frames_seen++;
        for (int k = 0; k < CHANNELS; k++) begin
            r.idx = IDX_W'(k);
            r.value = held_ch[k];
            r.ok = ok;
            r.ever = held_ever;
            r.ms = held_ms;
            r.last = (k == CHANNELS - 1);
            burst_q.push_back(r);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic [MS_W-1:0] now);
        int gap;
        gap = (tx_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {now, b};
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, now);
        words_sent++;
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [15:0] sum_err,
                              input fill_e fill, input logic [MS_W-1:0] stamp, input int len);
        logic [7:0]  f [32];
        logic [15:0] sum;
        f[0] = SYNC_BYTE;
        f[1] = hdr;
        for (int i = 2; i < 30; i++) begin
            case (fill)
                FILL_ZERO: f[i] = 8'h00;
                FILL_ONES: f[i] = 8'hFF;
                FILL_RAMP: f[i] = 8'(i * 37 + 5);
                default:   f[i] = 8'($urandom);
            endcase
        end
        sum = SUM_START;
        for (int i = 0; i < 30; i++) begin
            sum = sum - 16'(f[i]);
        end
        {f[31], f[30]} = sum ^ sum_err;
        for (int i = 0; i < len; i++) begin
            send_word(f[i], (i == 31) ? stamp : MS_W'($urandom));
        end
    endtask

    always @(negedge aclk) begin
        if (rx_calm_left == 0) begin
            rx_calm = ($urandom_range(0, 3) == 0);
            rx_calm_left = $urandom_range(40, 200);
        end else begin
            rx_calm_left--;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            rx_hold = idle_len() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (burst_q.size() == 0) begin
                $error("unexpected output word: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                failed = 1'b1;
            end else begin
                head_rpt = burst_q.pop_front();
                if (m_tdata[3:0] !== head_rpt.idx) begin
                    $error("channel_index: expected %0d, got %0d", head_rpt.idx, m_tdata[3:0]);
                    failed = 1'b1;
                end
                if (m_tdata[19:4] !== head_rpt.value) begin
                    $error("channel_value: expected %h, got %h", head_rpt.value, m_tdata[19:4]);
                    failed = 1'b1;
                end
                if (m_tdata[51:20] !== head_rpt.ms) begin
                    $error("last_frame_ms: expected %h, got %h", head_rpt.ms, m_tdata[51:20]);
                    failed = 1'b1;
                end
                if (m_tuser[0] !== head_rpt.ok) begin
                    $error("frame_ok: expected %b, got %b", head_rpt.ok, m_tuser[0]);
                    failed = 1'b1;
                end
                if (m_tuser[1] !== head_rpt.ever) begin
                    $error("ever_good: expected %b, got %b", head_rpt.ever, m_tuser[1]);
                    failed = 1'b1;
                end
                if (m_tlast !== head_rpt.last) begin
                    $error("last_of_frame: expected %b, got %b", head_rpt.last, m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int         pick;
        int         base;
        bit         paused;
        frame_row_t row;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        paused = 1'b0;
        for (int k = 0; k < CHANNELS; k++) begin
            rx_pend[k] = '0;
            held_ch[k] = '0;
        end
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < NUM_ROWS; n++) begin
            row = FRAME_PLAN[n];
            tx_calm = (n == 3);
            for (int i = 0; i < row.lead; i++) begin
                send_word(IDLE_PATTERN[idle_seq % 6], MS_W'($urandom));
                idle_seq++;
            end
            send_frame(row.hdr, row.sum_err, row.fill, row.stamp, 32);
            if (row.typed) begin
                base = burst_q.size() - CHANNELS;
                for (int k = 0; k < CHANNELS; k++) begin
                    burst_q[base + k].ok = row.t_ok;
                    burst_q[base + k].ever = row.t_ever;
                    burst_q[base + k].value = row.t_val;
                    burst_q[base + k].ms = row.t_ms;
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (burst_q.size() == 0);
        words_sent = 0;
        frames_seen = 0;
        while (words_sent < 32 || frames_seen < 1) begin
            if (!paused && words_sent >= 16) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (burst_q.size() == 0);
                paused = 1'b1;
            end
            tx_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                while (rx_pos != 0) begin
                    send_word(8'($urandom), MS_W'($urandom));
                end
                repeat ($urandom_range(0, 3)) send_word(noise_byte(), MS_W'($urandom));
                send_frame(($urandom_range(0, 99) < 85) ? CMD_BYTE : 8'($urandom),
                           ($urandom_range(0, 99) < 80) ? 16'h0 : 16'($urandom_range(1, 65535)),
                           fill_e'($urandom_range(0, 3)), MS_W'($urandom), 32);
            end else if (pick < 85) begin
                send_frame(8'($urandom), 16'h0, FILL_RAND, MS_W'($urandom),
                           $urandom_range(1, 31));
            end else begin
                repeat ($urandom_range(1, 6)) send_word(8'($urandom), MS_W'($urandom));
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        wait (burst_q.size() == 0);
        repeat (20) @(posedge aclk);
        if (!failed) begin
            $display("PASS rc_servo_frame_parser_top");
        end else begin
            $display("FAIL rc_servo_frame_parser_top");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL rc_servo_frame_parser_top");
        $finish;
    end

endmodule
